// ===== design/oamdmc_pkg.sv =====
package oamdmc_pkg;

  // Fixed bus addresses
  localparam logic [15:0] OAM_DATA_PORT = 16'h2004;
  localparam logic [15:0] JOY1_PORT     = 16'h4016;
  localparam logic [15:0] JOY2_PORT     = 16'h4017;

  // Kind of the read issued on the previous transfer
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PLAIN = 2'd1,
    KIND_DMC   = 2'd2,
    KIND_ALT   = 2'd3
  } read_kind_t;

  // One CPU bus cycle presented to the sequencer
  typedef struct packed {
    logic        cpu_valid;
    logic        cpu_write;
    logic [15:0] cpu_address;
    logic [7:0]  cpu_wdata;
    logic [7:0]  bus_rdata;
    logic        oam_start;
    logic [7:0]  oam_page;
    logic        dmc_request;
    logic [15:0] dmc_address;
  } req_t;

  // One bus operation and its status
  typedef struct packed {
    logic        bus_active;
    logic        bus_write;
    logic [15:0] bus_address;
    logic [7:0]  bus_wdata;
    logic        cpu_done;
    logic        dma_busy;
    logic        dmc_byte_valid;
    logic [7:0]  dmc_byte;
  } rsp_t;

endpackage

// ===== design/oam_dmc_dma_sequencer.sv =====
// Channel   Handshake            Payload             Direction
// req       req_valid/req_stall  oamdmc_pkg::req_t   into the block
// rsp       rsp_valid/rsp_stall  oamdmc_pkg::rsp_t   out of the block
//
// One transfer on req gives one transfer on rsp, registered in the cycle after it is accepted.
// Throughput is one item per clock while rsp is not stalled: the whole decision is one combinational
// pass from the req port into the rsp output register.
// req_stall is high only while the output register is full and rsp is stalled.
// rst is synchronous: it clears all sequencer state and empties the output register.
module oam_dmc_dma_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  oamdmc_pkg::req_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output oamdmc_pkg::rsp_t  rsp
);

  // Sequencer state
  logic                   put_parity;
  logic                   oam_pending;
  logic                   dmc_pending;
  logic                   dmc_aligned;
  logic                   oam_write_ready;
  logic [7:0]             oam_count;
  logic [7:0]             oam_source_page;
  logic                   halted;
  logic [15:0]            halted_address;
  logic                   skip_dummy;
  logic [7:0]             open_bus;
  oamdmc_pkg::read_kind_t last_read_kind;
  logic [15:0]            dmc_fetch_address;

  logic                   oam_pending_next;
  logic                   dmc_pending_next;
  logic                   dmc_aligned_next;
  logic                   oam_write_ready_next;
  logic [7:0]             oam_count_next;
  logic [7:0]             oam_source_page_next;
  logic                   halted_next;
  logic [15:0]            halted_address_next;
  logic                   skip_dummy_next;
  logic [7:0]             open_bus_next;
  oamdmc_pkg::read_kind_t last_read_kind_next;
  logic [15:0]            dmc_fetch_address_next;
  oamdmc_pkg::rsp_t       rsp_next;

  logic                   accept;
  logic [7:0]             count_inc;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // Decide one bus operation per transfer
  always_comb begin
    rsp_next               = '0;
    count_inc              = '0;
    last_read_kind_next    = oamdmc_pkg::KIND_NONE;
    open_bus_next          = open_bus;
    oam_pending_next       = oam_pending;
    dmc_pending_next       = dmc_pending;
    dmc_aligned_next       = dmc_aligned;
    oam_write_ready_next   = oam_write_ready;
    oam_count_next         = oam_count;
    oam_source_page_next   = oam_source_page;
    halted_next            = halted;
    halted_address_next    = halted_address;
    skip_dummy_next        = skip_dummy;
    dmc_fetch_address_next = dmc_fetch_address;

    // Capture read data from the previous transfer
    if (last_read_kind != oamdmc_pkg::KIND_NONE) begin
      open_bus_next = req.bus_rdata;
      if (last_read_kind == oamdmc_pkg::KIND_DMC) begin
        rsp_next.dmc_byte_valid = 1'b1;
        rsp_next.dmc_byte       = req.bus_rdata;
      end
    end

    // Take DMA requests
    if (req.oam_start) begin
      oam_pending_next     = 1'b1;
      oam_source_page_next = req.oam_page;
      oam_count_next       = '0;
      oam_write_ready_next = 1'b0;
    end
    if (req.dmc_request) begin
      dmc_pending_next       = 1'b1;
      dmc_aligned_next       = 1'b0;
      dmc_fetch_address_next = req.dmc_address;
    end

    // Choose the bus operation
    if (!halted) begin
      if (req.cpu_valid) begin
        if (req.cpu_write) begin
          rsp_next.bus_active  = 1'b1;
          rsp_next.bus_write   = 1'b1;
          rsp_next.bus_address = req.cpu_address;
          rsp_next.bus_wdata   = req.cpu_wdata;
          rsp_next.cpu_done    = 1'b1;
        end else begin
          rsp_next.bus_active  = 1'b1;
          rsp_next.bus_address = req.cpu_address;
          last_read_kind_next  = oamdmc_pkg::KIND_PLAIN;
          if (oam_pending_next || dmc_pending_next) begin
            // Halt read: the CPU stalls from here on
            halted_next          = 1'b1;
            halted_address_next  = req.cpu_address;
            skip_dummy_next      = (req.cpu_address == oamdmc_pkg::JOY1_PORT) ||
                                   (req.cpu_address == oamdmc_pkg::JOY2_PORT);
            oam_count_next       = '0;
            oam_write_ready_next = 1'b0;
            rsp_next.dma_busy    = 1'b1;
          end else begin
            rsp_next.cpu_done = 1'b1;
          end
        end
      end
    end else if (!oam_pending_next && !dmc_pending_next) begin
      // Release the stall and finish the held read
      rsp_next.bus_active  = 1'b1;
      rsp_next.bus_address = halted_address;
      last_read_kind_next  = oamdmc_pkg::KIND_PLAIN;
      halted_next          = 1'b0;
      rsp_next.cpu_done    = 1'b1;
    end else begin
      rsp_next.dma_busy = 1'b1;
      if (put_parity) begin
        if (oam_pending_next && oam_write_ready_next) begin
          // Put cycle: write the latched byte to the sprite port
          rsp_next.bus_active  = 1'b1;
          rsp_next.bus_write   = 1'b1;
          rsp_next.bus_address = oamdmc_pkg::OAM_DATA_PORT;
          rsp_next.bus_wdata   = open_bus_next;
          oam_write_ready_next = 1'b0;
          count_inc            = oam_count_next + 8'd1;
          oam_count_next       = count_inc;
          if (count_inc == 8'd0) begin
            oam_pending_next = 1'b0;
          end
        end else begin
          dmc_aligned_next = 1'b1;
          if (!skip_dummy) begin
            rsp_next.bus_active  = 1'b1;
            rsp_next.bus_address = halted_address;
            last_read_kind_next  = oamdmc_pkg::KIND_PLAIN;
          end
        end
      end else begin
        if (dmc_pending_next && dmc_aligned_next) begin
          // Get cycle: fetch the DMC sample byte
          rsp_next.bus_active  = 1'b1;
          rsp_next.bus_address = dmc_fetch_address_next;
          last_read_kind_next  = oamdmc_pkg::KIND_DMC;
          dmc_pending_next     = 1'b0;
        end else if (oam_pending_next) begin
          // Get cycle: read the next sprite byte
          if (dmc_pending_next) begin
            dmc_aligned_next = 1'b1;
          end
          rsp_next.bus_active  = 1'b1;
          rsp_next.bus_address = {oam_source_page_next, oam_count_next};
          last_read_kind_next  = oamdmc_pkg::KIND_PLAIN;
          oam_write_ready_next = 1'b1;
        end else begin
          dmc_aligned_next = 1'b1;
          if (!skip_dummy) begin
            rsp_next.bus_active  = 1'b1;
            rsp_next.bus_address = halted_address;
            last_read_kind_next  = oamdmc_pkg::KIND_PLAIN;
          end
        end
      end
    end
  end

  // Advance state on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      put_parity        <= 1'b0;
      oam_pending       <= 1'b0;
      dmc_pending       <= 1'b0;
      dmc_aligned       <= 1'b0;
      oam_write_ready   <= 1'b0;
      oam_count         <= '0;
      oam_source_page   <= '0;
      halted            <= 1'b0;
      halted_address    <= '0;
      skip_dummy        <= 1'b0;
      open_bus          <= '0;
      last_read_kind    <= oamdmc_pkg::KIND_NONE;
      dmc_fetch_address <= '0;
    end else if (accept) begin
      put_parity        <= !put_parity;
      oam_pending       <= oam_pending_next;
      dmc_pending       <= dmc_pending_next;
      dmc_aligned       <= dmc_aligned_next;
      oam_write_ready   <= oam_write_ready_next;
      oam_count         <= oam_count_next;
      oam_source_page   <= oam_source_page_next;
      halted            <= halted_next;
      halted_address    <= halted_address_next;
      skip_dummy        <= skip_dummy_next;
      open_bus          <= open_bus_next;
      last_read_kind    <= last_read_kind_next;
      dmc_fetch_address <= dmc_fetch_address_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // A DMC fetch read is followed by delivery of its byte
  assert property (@(posedge clk) disable iff (rst)
    (accept && last_read_kind == oamdmc_pkg::KIND_DMC) |=>
      (rsp_valid && rsp.dmc_byte_valid))
    else $error("DMC fetch not delivered");

  // A CPU access never completes while the CPU is halted
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.cpu_done && rsp.dma_busy))
    else $error("cpu_done during DMA stall");

  // The only write during a stall goes to the sprite data port
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.dma_busy && rsp.bus_write) |->
      (rsp.bus_address == oamdmc_pkg::OAM_DATA_PORT))
    else $error("stall write to wrong address");

  // Leaving the halt always finishes the held CPU read
  assert property (@(posedge clk) disable iff (rst)
    (accept && halted && !halted_next) |=>
      (rsp.cpu_done && rsp.bus_active && !rsp.bus_write))
    else $error("stall release without CPU read");
`endif

endmodule
